@@ design/rtmt_pkg.sv @@
package rtmt_pkg;

    localparam int SLOTS     = 32;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ID_BITS   = 8;
    localparam int TAG_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int TARGET_W  = 8;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 136;
    localparam int M_DATA_W  = 80;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXCHANGED = 2'd0,
        ST_FULL      = 2'd1,
        ST_DISABLED  = 2'd2
    } status_code_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         capture;     // latch the accepted request
        logic         compare;     // register the per-slot tag matches
        logic         pick;        // register the lowest hit and free slot
        logic         park;        // write the request into the free slot
        logic         take;        // free the hit slot
        logic         load_err;    // load an error result
        status_code_t err_status;
        logic         load_res0;   // result for the arriving requester
        logic         load_res1;   // result for the parked waiter
    } rtmt_cmd_t;

    typedef struct packed {
        logic enable;
        logic hit_found;
        logic free_found;
    } rtmt_stat_t;

endpackage

@@ design/rtmt_ctrl.sv @@
module rtmt_ctrl
    import rtmt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  rtmt_stat_t stat,
    output rtmt_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CMP    = 7'b0000010,
        S_PICK   = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_READ   = 7'b0010000,
        S_SEND0  = 7'b0100000,
        S_LAST   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.err_status = ST_FULL;
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP: begin
                cmd.compare = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK: begin
                cmd.pick   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (!stat.enable) begin
                    cmd.load_err   = 1'b1;
                    cmd.err_status = ST_DISABLED;
                    state_next     = S_LAST;
                end else if (stat.hit_found) begin
                    cmd.take   = 1'b1;
                    state_next = S_READ;
                end else if (stat.free_found) begin
                    cmd.park   = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.load_err   = 1'b1;
                    cmd.err_status = ST_FULL;
                    state_next     = S_LAST;
                end
            end
            S_READ: begin
                cmd.load_res0 = 1'b1;
                state_next    = S_SEND0;
            end
            S_SEND0: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.load_res1 = 1'b1;
                    state_next    = S_LAST;
                end
            end
            S_LAST: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/rtmt_datapath.sv @@
module rtmt_datapath
    import rtmt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [TAG_W-1:0]    in_tag,
    input  logic [VALUE_W-1:0]  in_offer,
    input  logic [ID_BITS-1:0]  in_who,
    input  rtmt_cmd_t           cmd,
    output rtmt_stat_t          stat,
    output logic [TARGET_W-1:0] out_target,
    output logic [VALUE_W-1:0]  out_value,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_last
);

    localparam int ENTRY_W = ID_BITS + VALUE_W;

    logic                enable_reg;
    logic [SLOTS-1:0]    busy_reg;
    logic [TAG_W-1:0]    slot_tag_reg [SLOTS];
    logic [ENTRY_W-1:0]  entry_mem [SLOTS];
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic [TAG_W-1:0]    tag_reg;
    logic [VALUE_W-1:0]  offer_reg;
    logic [ID_BITS-1:0]  who_reg;

    logic [SLOTS-1:0]    match_vec_reg, match_vec_next;
    logic [SLOTS-1:0]    free_vec_reg;
    logic [SLOTS-1:0]    hit_onehot, free_onehot;
    logic [SLOT_W-1:0]   hit_idx_reg, free_idx_reg;
    logic                hit_found_reg, free_found_reg;

    logic [TARGET_W-1:0] out_target_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    function automatic logic [SLOT_W-1:0] encode(input logic [SLOTS-1:0] onehot);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (onehot[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enable_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tag_reg   <= in_tag;
            offer_reg <= in_offer;
            who_reg   <= in_who;
        end
    end

    // Every slot compares its tag against the request in parallel.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_vec_next[i] = busy_reg[i] && (slot_tag_reg[i] == tag_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            match_vec_reg <= match_vec_next;
            free_vec_reg  <= ~busy_reg;
        end
    end

    // Isolate the lowest set bit of each vector before encoding it.
    assign hit_onehot  = match_vec_reg & (~match_vec_reg + SLOTS'(1));
    assign free_onehot = free_vec_reg & (~free_vec_reg + SLOTS'(1));

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            hit_idx_reg    <= encode(hit_onehot);
            free_idx_reg   <= encode(free_onehot);
            hit_found_reg  <= |match_vec_reg;
            free_found_reg <= |free_vec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else if (cmd.park) begin
            busy_reg[free_idx_reg] <= 1'b1;
        end else if (cmd.take) begin
            busy_reg[hit_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.park) begin
            slot_tag_reg[free_idx_reg] <= tag_reg;
        end
    end

    // Owner and value table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.park) begin
            entry_mem[free_idx_reg] <= {who_reg, offer_reg};
        end
        rd_data_reg <= entry_mem[hit_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_err) begin
            out_target_reg <= TARGET_W'(who_reg);
            out_value_reg  <= '0;
            out_status_reg <= cmd.err_status;
            out_last_reg   <= 1'b1;
        end else if (cmd.load_res0) begin
            out_target_reg <= TARGET_W'(who_reg);
            out_value_reg  <= rd_data_reg[VALUE_W-1:0];
            out_status_reg <= ST_EXCHANGED;
            out_last_reg   <= 1'b0;
        end else if (cmd.load_res1) begin
            out_target_reg <= TARGET_W'(rd_data_reg[ENTRY_W-1:VALUE_W]);
            out_value_reg  <= offer_reg;
            out_status_reg <= ST_EXCHANGED;
            out_last_reg   <= 1'b1;
        end
    end

    assign stat.enable     = enable_reg;
    assign stat.hit_found  = hit_found_reg;
    assign stat.free_found = free_found_reg;

    assign out_target = out_target_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

@@ design/rendezvous_tag_match_table.sv @@
// Rendezvous tag match table. A request (tag, offer value, requester id) is
// compared against every parked waiter at once; on a hit the lowest matching
// slot is freed and two beats follow: first the arriving requester receives
// the waiter's value, then the waiter receives the arriving value (tlast set).
// Without a hit the request parks in the lowest free slot and gives no beat;
// a full table or a cleared enable gives one error beat with zero value.
// One request is handled at a time: s_tready is high only in the idle state,
// so no request is taken until the last one is parked or its final beat is
// accepted. The sequencer runs a compare stage, a priority-pick stage and a
// decide stage; a match then passes a read state that loads the first beat
// from the registered read of the owner/value table. Result beats wait while
// m_tready is low. No clearing pass is needed after reset.
module rendezvous_tag_match_table
    import rtmt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // tag [63:0], offer_value [127:64], requester [135:128]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // target [7:0], partner_value [71:8], status [73:72], zero [79:74]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    rtmt_cmd_t           cmd;
    rtmt_stat_t          stat;
    logic [TARGET_W-1:0] out_target;
    logic [VALUE_W-1:0]  out_value;
    logic [STATUS_W-1:0] out_status;

    rtmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtmt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_tag      (s_tdata[TAG_W-1:0]),
        .in_offer    (s_tdata[TAG_W+VALUE_W-1:TAG_W]),
        .in_who      (s_tdata[TAG_W+VALUE_W+ID_BITS-1:TAG_W+VALUE_W]),
        .cmd         (cmd),
        .stat        (stat),
        .out_target  (out_target),
        .out_value   (out_value),
        .out_status  (out_status),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{(M_DATA_W - TARGET_W - VALUE_W - STATUS_W){1'b0}},
                      out_status, out_value, out_target};

endmodule

@@ design/rtmt_checker.sv @@
module rtmt_checker
    import rtmt_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    localparam int ST_LO = TARGET_W + VALUE_W;

    logic [STATUS_W-1:0] m_status;
    logic [VALUE_W-1:0]  m_value;
    logic                m_error;

    assign m_status = m_tdata[ST_LO+STATUS_W-1:ST_LO];
    assign m_value  = m_tdata[ST_LO-1:TARGET_W];
    assign m_error  = (m_status == ST_FULL) || (m_status == ST_DISABLED);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // No new request is taken while a result is pending.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request accepted while a result is pending");

    // An error is a single beat carrying a zero value.
    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_error |-> m_tlast && (m_value == '0))
        else $error("malformed error beat");

    // The first beat of an exchange is followed at once by its partner beat.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast &&
        (m_status == ST_EXCHANGED))
        else $error("exchange pair broken");

endmodule

bind rendezvous_tag_match_table rtmt_checker u_rtmt_checker (.*);

@@ sim/tb_rendezvous_tag_match_table.sv @@
`timescale 1ns / 100ps

module tb_rendezvous_tag_match_table;
    import rtmt_pkg::*;

    typedef struct {
        logic [TARGET_W-1:0] target;
        logic [VALUE_W-1:0]  value;
        status_code_t        status;
        logic                last;
    } beat_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    // tag [63:0], offer_value [127:64], requester [135:128]
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    // target [7:0], partner_value [71:8], status [73:72], zero [79:74]
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // Shadow copy of the table and of the enable register.
    logic                enabled;
    logic                waiter_busy  [SLOTS];
    logic [TAG_W-1:0]    waiter_tag   [SLOTS];
    logic [VALUE_W-1:0]  waiter_value [SLOTS];
    logic [TARGET_W-1:0] waiter_owner [SLOTS];
    beat_t               due_beats[$];

    int errors      = 0;
    int n_requests  = 0;
    int n_exchanged = 0;
    int n_parked    = 0;
    int n_full      = 0;
    int n_refused   = 0;
    int n_beats     = 0;
    int rx_wait     = 0;
    bit quiet       = 1'b0;

    rendezvous_tag_match_table uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Run did not complete in time.");
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return random64();
    endfunction

    // Works out the beats that one accepted request causes and updates the table.
    function automatic void resolve_request(logic [TAG_W-1:0] tag, logic [VALUE_W-1:0] offer,
                                            logic [7:0] requester);
        logic [TARGET_W-1:0] who;
        int                  hit;
        int                  vacant;
        who = TARGET_W'(requester[ID_BITS-1:0]);
        hit = -1;
        vacant = -1;
        n_requests++;
        if (!enabled) begin
            due_beats.push_back('{who, '0, ST_DISABLED, 1'b1});
            n_refused++;
            return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (waiter_busy[i]) begin
                if (hit < 0 && waiter_tag[i] == tag)
                    hit = i;
            end else if (vacant < 0) begin
                vacant = i;
            end
        end
        if (hit >= 0) begin
            waiter_busy[hit] = 1'b0;
            due_beats.push_back('{who, waiter_value[hit], ST_EXCHANGED, 1'b0});
            due_beats.push_back('{waiter_owner[hit], offer, ST_EXCHANGED, 1'b1});
            n_exchanged++;
        end else if (vacant >= 0) begin
            waiter_busy[vacant]  = 1'b1;
            waiter_tag[vacant]   = tag;
            waiter_value[vacant] = offer;
            waiter_owner[vacant] = who;
            n_parked++;
        end else begin
            due_beats.push_back('{who, '0, ST_FULL, 1'b1});
            n_full++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        $display("MISMATCH at %0t: %s, expected %0h, got %0h", $time, what, want, got);
    endtask

    // Valid is only lowered when a gap follows, so it never toggles within one step.
    task automatic send_request(logic [TAG_W-1:0] tag, logic [VALUE_W-1:0] offer,
                                logic [7:0] requester);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {requester, offer, tag};
        do @(posedge aclk); while (!s_tready);
        resolve_request(tag, offer, requester);
    endtask

    // A parked request gives no beat, so the block may still be busy once the
    // queue is empty; the extra cycles cover its longest sequence.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_beats.size() > 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_enable(logic on);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        enabled = on;
    endtask

    task automatic clear_table();
        logic [TAG_W-1:0] parked[$];
        for (int i = 0; i < SLOTS; i++)
            if (waiter_busy[i])
                parked.push_back(waiter_tag[i]);
        foreach (parked[k])
            send_request(parked[k], pick_value(), 8'($urandom));
        drain();
    endtask

    task automatic test_disabled_block();
        send_request('0, '0, 8'h00);
        send_request('1, '1, 8'hFF);
        send_request(random64(), random64(), 8'h5A);
        drain();
    endtask

    task automatic test_exchange();
        set_enable(1'b1);
        send_request('1, '1, 8'h00);
        send_request('1, '0, 8'hFF);
        // A requester meeting its own parked request is an ordinary match.
        send_request('0, 64'h0123_4567_89AB_CDEF, 8'h80);
        send_request('0, 64'hFEDC_BA98_7654_3210, 8'h80);
        send_request(64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 8'h01);
        send_request(64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 8'h7F);
        drain();
        // Waiters must survive a spell with the block disabled.
        set_enable(1'b0);
        send_request(64'h5555_AAAA_5555_AAAA, random64(), 8'h02);
        send_request(64'h1234, random64(), 8'hFE);
        drain();
        set_enable(1'b1);
        send_request(64'h5555_AAAA_5555_AAAA, '1, 8'h03);
        send_request(64'hAAAA_5555_AAAA_5555, '0, 8'h04);
        drain();
    endtask

    task automatic test_table_full();
        int busy;
        logic [TAG_W-1:0] first_tag;
        busy = 0;
        for (int i = 0; i < SLOTS; i++)
            busy += waiter_busy[i];
        first_tag = 64'hF000_0000_0000_0000;
        for (int i = busy; i < SLOTS; i++)
            send_request(first_tag + i, random64(), 8'($urandom));
        send_request(64'hE000_0000_0000_0001, random64(), 8'h11);
        // A hit is still served while every slot is taken.
        send_request(first_tag + SLOTS - 1, random64(), 8'h22);
        send_request(64'hE000_0000_0000_0002, random64(), 8'h33);
        send_request(64'hE000_0000_0000_0003, random64(), 8'h44);
        drain();
        clear_table();
    endtask

    task automatic run_random_phase(int items, int pool_size, logic on);
        logic [TAG_W-1:0] tag_pool[$];
        logic [TAG_W-1:0] tag;
        set_enable(on);
        for (int i = 0; i < pool_size; i++)
            tag_pool.push_back(i == 0 ? '0 : (i == 1 ? '1 : random64()));
        for (int n = 0; n < items; n++) begin
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                tag = random64();
            else
                tag = tag_pool[$urandom_range(0, pool_size - 1)];
            send_request(tag, pick_value(), 8'($urandom));
        end
        quiet = 1'b0;
        drain();
        clear_table();
    endtask

    task automatic test_random_traffic();
        run_random_phase(300, 4, 1'b1);
        run_random_phase(300, 16, 1'b1);
        run_random_phase(250, 200, 1'b1);
        run_random_phase(100, 8, 1'b0);
        run_random_phase(300, 40, 1'b1);
        run_random_phase(150, 8, 1'b1);
    endtask

    // Result side: a random stall after every beat, none while quiet is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else if (m_tvalid && m_tready) begin
            rx_wait = quiet ? 0 : $urandom_range(0, 15);
            m_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= (rx_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_beats++;
            if (due_beats.size() == 0) begin
                report_mismatch("beat with nothing expected", '0, 64'(m_tdata));
            end else begin
                want = due_beats.pop_front();
                if (m_tdata[7:0] != want.target)
                    report_mismatch("target", 64'(want.target), 64'(m_tdata[7:0]));
                if (m_tdata[71:8] != want.value)
                    report_mismatch("partner_value", want.value, m_tdata[71:8]);
                if (m_tdata[73:72] != want.status)
                    report_mismatch("status", 64'(want.status), 64'(m_tdata[73:72]));
                if (m_tlast != want.last)
                    report_mismatch("tlast", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    initial begin
        enabled = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            waiter_busy[i] = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_block();
        test_exchange();
        test_table_full();
        test_random_traffic();
        if (due_beats.size() != 0)
            report_mismatch("results never delivered", '0, 64'(due_beats.size()));
        $display("Sent %0d requests: %0d exchanges, %0d parked, %0d refused as full, %0d as disabled.",
                 n_requests, n_exchanged, n_parked, n_full, n_refused);
        $display("Checked %0d result beats, %0d mismatches.", n_beats, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ rendezvous_tag_match_table.f @@
design/rtmt_pkg.sv
design/rtmt_ctrl.sv
design/rtmt_datapath.sv
design/rendezvous_tag_match_table.sv
design/rtmt_checker.sv
sim/tb_rendezvous_tag_match_table.sv
